// ----- rtl/core/ptwl_pkg.sv -----
`timescale 1ns / 1ps
// Package for the proportional text width locator.
// Shared codes, widths, reset values and the stage control struct; no dependencies.
package ptwl_pkg;

   localparam int TABLE_DEPTH = 257;
   localparam int TABLE_AW    = 9;

   localparam logic [7:0] FALLBACK_CODE  = 8'h3f;
   localparam logic [5:0] FIRST_CODE_RST = 6'h00;
   localparam logic [7:0] LAST_CODE_RST  = 8'hff;

   localparam logic [1:0] KIND_OFFSET = 2'd0;
   localparam logic [1:0] KIND_ADJUST = 2'd1;
   localparam logic [1:0] KIND_CHAR   = 2'd2;

   localparam logic [1:0] CSR_FIRST_CODE     = 2'd0;
   localparam logic [1:0] CSR_LAST_CODE      = 2'd1;
   localparam logic [1:0] CSR_ADJUST_ENABLE  = 2'd2;
   localparam logic [1:0] CSR_NUL_TERMINATES = 2'd3;

   typedef struct packed {
      logic        is_nul;
      logic        first_char;
      logic        last_char;
      logic        locate_mode;
      logic [15:0] target_offset;
   } char_ctrl_type;

endpackage

// ----- rtl/core/proportional_text_width_locator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the proportional text width locator: input stage, glyph index, table read, width stage, string track.
// Depends on ptwl_pkg, ptwl_glyph_mem and ptwl_string_track.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  kind, table index, load values, char fields
//   rsp      out        rsp_valid / rsp_ready  locate flag, found, width and locate fields
//   csr      in         csr_we                 csr_index, csr_data
//
// One beat per cycle sustained while rsp is not stalled. A character's beat passes the
// input register, the table read, the width register and the result register, and
// its result leaves from the result register. Reset clears control state only; tables
// hold garbage until loaded, no clearing pass.
// A stalled rsp holds the result register; the three stages behind it keep filling,
// and req_ready drops once all of them hold an item.
module proportional_text_width_locator_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [8:0]         req_table_index,
   input  logic [15:0]        req_offset_value,
   input  logic signed [7:0]  req_adjust_value,
   input  logic [7:0]         req_char_code,
   input  logic               req_first_char,
   input  logic               req_last_char,
   input  logic               req_locate_mode,
   input  logic signed [15:0] req_target_offset,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_is_locate,
   output logic               rsp_found,
   output logic signed [15:0] rsp_total_width,
   output logic [14:0]        rsp_char_index,
   output logic signed [15:0] rsp_char_start,
   output logic signed [15:0] rsp_char_width,
   output logic signed [15:0] rsp_offset_in_char,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_data
);
   import ptwl_pkg::*;

   logic [5:0] first_code_ff;
   logic [7:0] last_code_ff;
   logic       adjust_enable_ff;
   logic       nul_terminates_ff;

   logic        s1_valid_ff;
   logic [1:0]  s1_kind_ff;
   logic [8:0]  s1_tidx_ff;
   logic [15:0] s1_offset_ff;
   logic [7:0]  s1_adjust_ff;
   logic [7:0]  s1_code_ff;
   logic        s1_first_ff;
   logic        s1_last_ff;
   logic        s1_locate_ff;
   logic [15:0] s1_target_ff;

   logic          s2_valid_ff;
   char_ctrl_type s2_ctrl_ff;
   logic          s3_valid_ff;
   char_ctrl_type s3_ctrl_ff;
   logic [15:0]   s3_width_ff;

   logic          s1_adv, s2_adv, s3_adv;
   logic          s3_ready;
   logic          code_ok;
   logic [7:0]    code_eff;
   logic [7:0]    glyph_idx;
   logic          tidx_ok;
   logic          wr_offset_en, wr_adjust_en;
   char_ctrl_type s1_ctrl;
   logic [15:0]   off_lo, off_hi;
   logic [7:0]    adj_lo, adj_hi;
   logic [15:0]   adj_sum;
   logic [15:0]   width_in;

   assign s3_adv    = !s3_valid_ff || s3_ready;
   assign s2_adv    = !s2_valid_ff || s3_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_code_ff     <= FIRST_CODE_RST;
         last_code_ff      <= LAST_CODE_RST;
         adjust_enable_ff  <= 1'b0;
         nul_terminates_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_CODE:     first_code_ff     <= csr_data[5:0];
            CSR_LAST_CODE:      last_code_ff      <= csr_data;
            CSR_ADJUST_ENABLE:  adjust_enable_ff  <= csr_data[0];
            CSR_NUL_TERMINATES: nul_terminates_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_kind_ff   <= req_kind;
         s1_tidx_ff   <= req_table_index;
         s1_offset_ff <= req_offset_value;
         s1_adjust_ff <= req_adjust_value;
         s1_code_ff   <= req_char_code;
         s1_first_ff  <= req_first_char;
         s1_last_ff   <= req_last_char;
         s1_locate_ff <= req_locate_mode;
         s1_target_ff <= req_target_offset;
      end
   end

   // Glyph index: out-of-range codes fall back to '?'
   assign code_ok   = (s1_code_ff >= {2'b00, first_code_ff}) && (s1_code_ff <= last_code_ff);
   assign code_eff  = code_ok ? s1_code_ff : FALLBACK_CODE;
   assign glyph_idx = code_eff - {2'b00, first_code_ff};

   assign tidx_ok      = s1_tidx_ff < 9'(TABLE_DEPTH);
   assign wr_offset_en = s1_valid_ff && s2_adv && tidx_ok && (s1_kind_ff == KIND_OFFSET);
   assign wr_adjust_en = s1_valid_ff && s2_adv && tidx_ok && (s1_kind_ff == KIND_ADJUST);

   assign s1_ctrl.is_nul        = nul_terminates_ff && (s1_code_ff == 8'd0);
   assign s1_ctrl.first_char    = s1_first_ff;
   assign s1_ctrl.last_char     = s1_last_ff;
   assign s1_ctrl.locate_mode   = s1_locate_ff;
   assign s1_ctrl.target_offset = s1_target_ff;

   ptwl_glyph_mem u_glyph_mem (
      .clock        (clock),
      .wr_offset_en (wr_offset_en),
      .wr_adjust_en (wr_adjust_en),
      .wr_addr      (s1_tidx_ff),
      .wr_offset    (s1_offset_ff),
      .wr_adjust    (s1_adjust_ff),
      .rd_en        (s2_adv),
      .rd_idx       (glyph_idx),
      .offset_lo    (off_lo),
      .offset_hi    (off_hi),
      .adjust_lo    (adj_lo),
      .adjust_hi    (adj_hi)
   );

   // Table read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_valid_ff <= s1_valid_ff && (s1_kind_ff == KIND_CHAR);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_ctrl_ff <= s1_ctrl;
      end
   end

   // Width stage
   assign adj_sum  = {{8{adj_lo[7]}}, adj_lo} + {{8{adj_hi[7]}}, adj_hi};
   assign width_in = (off_hi - off_lo) + (adjust_enable_ff ? adj_sum : 16'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         s3_ctrl_ff  <= s2_ctrl_ff;
         s3_width_ff <= width_in;
      end
   end

   ptwl_string_track u_string_track (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (s3_valid_ff),
      .item_ctrl          (s3_ctrl_ff),
      .item_width         (s3_width_ff),
      .item_ready         (s3_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_locate      (rsp_is_locate),
      .rsp_found          (rsp_found),
      .rsp_total_width    (rsp_total_width),
      .rsp_char_index     (rsp_char_index),
      .rsp_char_start     (rsp_char_start),
      .rsp_char_width     (rsp_char_width),
      .rsp_offset_in_char (rsp_offset_in_char)
   );

endmodule

// ----- rtl/core/ptwl_glyph_mem.sv -----
`timescale 1ns / 1ps
// Glyph offset and adjust tables, one write port and two registered read ports each.
// Uses ptwl_pkg for the table depth.
module ptwl_glyph_mem (
   input  logic                        clock,
   input  logic                        wr_offset_en,
   input  logic                        wr_adjust_en,
   input  logic [ptwl_pkg::TABLE_AW-1:0] wr_addr,
   input  logic [15:0]                 wr_offset,
   input  logic [7:0]                  wr_adjust,
   input  logic                        rd_en,
   input  logic [7:0]                  rd_idx,
   output logic [15:0]                 offset_lo,
   output logic [15:0]                 offset_hi,
   output logic [7:0]                  adjust_lo,
   output logic [7:0]                  adjust_hi
);
   import ptwl_pkg::*;

   logic [15:0] offset_mem [TABLE_DEPTH];
   logic [7:0]  adjust_mem [TABLE_DEPTH];

   logic [TABLE_AW-1:0] addr_lo;
   logic [TABLE_AW-1:0] addr_hi;

   assign addr_lo = {1'b0, rd_idx};
   assign addr_hi = addr_lo + 9'd1;

   always_ff @(posedge clock) begin
      if (wr_offset_en) begin
         offset_mem[wr_addr] <= wr_offset;
      end
      if (wr_adjust_en) begin
         adjust_mem[wr_addr] <= wr_adjust;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         offset_lo <= offset_mem[addr_lo];
         offset_hi <= offset_mem[addr_hi];
         adjust_lo <= adjust_mem[addr_lo];
         adjust_hi <= adjust_mem[addr_hi];
      end
   end

endmodule

// ----- rtl/core/ptwl_string_track.sv -----
`timescale 1ns / 1ps
// String state (running width, remaining target, character count) and result register.
// Uses ptwl_pkg for the character control struct.
module ptwl_string_track (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  ptwl_pkg::char_ctrl_type item_ctrl,
   input  logic [15:0]             item_width,
   output logic                    item_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_is_locate,
   output logic                    rsp_found,
   output logic [15:0]             rsp_total_width,
   output logic [14:0]             rsp_char_index,
   output logic [15:0]             rsp_char_start,
   output logic [15:0]             rsp_char_width,
   output logic [15:0]             rsp_offset_in_char
);
   import ptwl_pkg::*;

   logic [15:0] run_ff, run_in;
   logic [15:0] rem_ff, rem_in;
   logic [14:0] passed_ff, passed_in;
   logic        mode_ff, mode_in;
   logic        done_ff, done_in;

   logic        valid_ff;
   logic        is_locate_ff, is_locate_in;
   logic        found_ff, found_in;
   logic [15:0] total_ff, total_in;
   logic [14:0] index_ff, index_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] cwidth_ff, cwidth_in;
   logic [15:0] inchar_ff, inchar_in;

   logic        fire;
   logic        has_rsp;
   logic        mode_cur;
   logic [15:0] run_cur;
   logic [15:0] rem_cur;
   logic [14:0] passed_cur;
   logic [15:0] run_sum;
   logic [15:0] rem_diff;

   assign item_ready = !valid_ff || rsp_ready;
   assign fire       = item_valid && item_ready;

   assign mode_cur   = item_ctrl.first_char ? item_ctrl.locate_mode   : mode_ff;
   assign run_cur    = item_ctrl.first_char ? 16'd0                   : run_ff;
   assign rem_cur    = item_ctrl.first_char ? item_ctrl.target_offset : rem_ff;
   assign passed_cur = item_ctrl.first_char ? 15'd0                   : passed_ff;
   assign run_sum    = run_cur + item_width;
   assign rem_diff   = rem_cur - item_width;

   always_comb begin
      run_in       = run_ff;
      rem_in       = rem_ff;
      passed_in    = passed_ff;
      mode_in      = mode_ff;
      done_in      = done_ff;
      has_rsp      = 1'b0;
      is_locate_in = mode_cur;
      found_in     = 1'b0;
      total_in     = '0;
      index_in     = '0;
      start_in     = '0;
      cwidth_in    = '0;
      inchar_in    = '0;
      if (fire && (item_ctrl.first_char || !done_ff)) begin
         mode_in   = mode_cur;
         run_in    = run_cur;
         rem_in    = rem_cur;
         passed_in = passed_cur;
         done_in   = 1'b0;
         if (item_ctrl.is_nul) begin
            done_in = 1'b1;
            has_rsp = 1'b1;
            if (!mode_cur) begin
               total_in = run_cur;
            end
         end else if (!mode_cur) begin
            run_in = run_sum;
            if (item_ctrl.last_char) begin
               done_in  = 1'b1;
               has_rsp  = 1'b1;
               total_in = run_sum;
            end
         end else begin
            rem_in = rem_diff;
            if (rem_diff == 16'd0 || rem_diff[15]) begin
               done_in   = 1'b1;
               has_rsp   = 1'b1;
               found_in  = 1'b1;
               index_in  = passed_cur;
               start_in  = run_cur;
               cwidth_in = item_width;
               inchar_in = rem_cur;
            end else begin
               passed_in = passed_cur + 15'd1;
               run_in    = run_sum;
               if (item_ctrl.last_char) begin
                  done_in = 1'b1;
                  has_rsp = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= '0;
         rem_ff     <= '0;
         passed_ff  <= '0;
         mode_ff    <= 1'b0;
         done_ff    <= 1'b1;
         valid_ff   <= 1'b0;
      end else begin
         run_ff     <= run_in;
         rem_ff     <= rem_in;
         passed_ff  <= passed_in;
         mode_ff    <= mode_in;
         done_ff    <= done_in;
         if (fire && has_rsp) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && has_rsp) begin
         is_locate_ff <= is_locate_in;
         found_ff     <= found_in;
         total_ff     <= total_in;
         index_ff     <= index_in;
         start_ff     <= start_in;
         cwidth_ff    <= cwidth_in;
         inchar_ff    <= inchar_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_is_locate      = is_locate_ff;
   assign rsp_found          = found_ff;
   assign rsp_total_width    = total_ff;
   assign rsp_char_index     = index_ff;
   assign rsp_char_start     = start_ff;
   assign rsp_char_width     = cwidth_ff;
   assign rsp_offset_in_char = inchar_ff;

endmodule

// ----- rtl/core/ptwl_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the proportional text width locator, bound to the top level.
// Depends only on the top level's ports.
module ptwl_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_is_locate,
   input logic               rsp_found,
   input logic signed [15:0] rsp_total_width,
   input logic [14:0]        rsp_char_index,
   input logic signed [15:0] rsp_char_start,
   input logic signed [15:0] rsp_char_width,
   input logic signed [15:0] rsp_offset_in_char
);

   logic [15:0] fit_diff;

   assign fit_diff = rsp_offset_in_char - rsp_char_width;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_width))
      else $error("rsp beat dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_found_is_locate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_is_locate && rsp_total_width == 16'sd0)
      else $error("found flag on a width result");

   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_char_index == 15'd0 && rsp_char_start == 16'sd0
         && rsp_char_width == 16'sd0 && rsp_offset_in_char == 16'sd0)
      else $error("locate fields set without a hit");

   a_hit_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> fit_diff == 16'd0 || fit_diff[15])
      else $error("target does not fall inside the reported character");

endmodule

bind proportional_text_width_locator_unit ptwl_checker u_ptwl_checker (.*);
